// ===== src/chhist_pkg.sv =====
// ----------------------------------------------------------------------------
// chhist_pkg
// Shared types, codes and helpers of the channel hit histogram.
// ----------------------------------------------------------------------------
package chhist_pkg;

    // default geometry
    localparam int ARMS_DEF   = 2;
    localparam int SIDES_DEF  = 2;
    localparam int PLANES_DEF = 40;
    localparam int CELLS_DEF  = 80;

    // highest cell number that is ever counted
    localparam logic [6:0] CELL_LIMIT = 7'd79;

    localparam int CNT_W = 24;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // configuration registers
    localparam int CFG_W  = 16;
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] REG_THRESHOLD   = 1'd0;
    localparam logic [CFG_AW-1:0] REG_REQ_TRIGGER = 1'd1;
    localparam logic [CFG_W-1:0]  THRESHOLD_RST   = 16'd128;

    // item kinds
    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_HIT    = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // channel classes
    localparam logic [1:0] CLASS_GOOD    = 2'd0;
    localparam logic [1:0] CLASS_NOISY   = 2'd1;
    localparam logic [1:0] CLASS_DEAD    = 2'd2;
    localparam logic [1:0] CLASS_UNKNOWN = 2'd3;

    // word widths on the stream ports
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 80;

    // both edge counts of one channel, one memory word
    typedef struct packed {
        logic [CNT_W-1:0] edge1;
        logic [CNT_W-1:0] edge0;
    } cnt_pair_t;

    // fields of an accepted word kept for the busy state
    typedef struct packed {
        logic [1:0] func;
        logic       edge_sel;
        logic       addr_ok;
    } item_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== src/channel_hit_histogram_noise_classifier.sv =====
// ----------------------------------------------------------------------------
// channel_hit_histogram_noise_classifier
// Per-channel hit histogram with event counting and channel classification.
// ----------------------------------------------------------------------------
// Each hit is a read-modify-write: the counter memory is read when the word is
// accepted and the incremented pair is written back in the busy state after it,
// and s_tready stays low in between, so no new word is taken before the last
// one is through. A query waits in the busy state while the previous
// result is still held on the master side. After reset the block clears the
// counter memory one entry per cycle, ARMS*SIDES*PLANES*CELLS entries (12800
// by default), before s_tready first rises; configuration writes are taken
// at any time.
module channel_hit_histogram_noise_classifier #(
    parameter int ARMS   = chhist_pkg::ARMS_DEF,
    parameter int SIDES  = chhist_pkg::SIDES_DEF,
    parameter int PLANES = chhist_pkg::PLANES_DEF,
    parameter int CELLS  = chhist_pkg::CELLS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // trigger_valid[0], arm[1], side[2], plane[8:3], cell_req[15:9], edge_req[16]
    input  logic [chhist_pkg::S_DATA_W-1:0]    s_tdata,
    // func[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // edge0_count[23:0], edge1_count[47:24], accepted_events[71:48],
    // channel_class[73:72]
    output logic [chhist_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [chhist_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [chhist_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int CHANNELS = ARMS * SIDES * PLANES * CELLS;
    localparam int AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW       = chhist_pkg::CNT_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_BUSY  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [AW-1:0] clr_addr_reg;

    logic [chhist_pkg::CFG_W-1:0] threshold_reg;
    logic                         req_trig_reg;
    logic [CW-1:0]                event_total_reg;
    logic                         event_open_reg;

    chhist_pkg::item_t item_reg;
    logic [AW-1:0]     idx_reg;

    logic                  out_valid_reg;
    logic [CW-1:0]         out_e0_reg;
    logic [CW-1:0]         out_e1_reg;
    logic [CW-1:0]         out_total_reg;
    logic [1:0]            out_class_reg;

    logic          accept;
    logic [1:0]    in_func;
    logic          in_trig;
    logic [AW-1:0] map_idx;
    logic          map_ok;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    chhist_pkg::cnt_pair_t mem_wr_data;
    chhist_pkg::cnt_pair_t mem_rd_data;
    chhist_pkg::cnt_pair_t hit_pair;

    logic       hit_write;
    logic       out_load;
    logic       out_free;
    logic [1:0] class_now;

    assign in_func  = s_tuser;
    assign in_trig  = s_tdata[0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    chhist_chan_map #(
        .ARMS   (ARMS),
        .SIDES  (SIDES),
        .PLANES (PLANES),
        .CELLS  (CELLS),
        .AW     (AW)
    ) u_chan_map (
        .arm     (s_tdata[1]),
        .side    (s_tdata[2]),
        .plane   (s_tdata[8:3]),
        .cell_no (s_tdata[15:9]),
        .idx     (map_idx),
        .ok      (map_ok)
    );

    // busy state of a hit: write back the incremented pair
    always_comb begin
        hit_pair = mem_rd_data;
        if (item_reg.edge_sel) begin
            hit_pair.edge1 = chhist_pkg::sat_inc(mem_rd_data.edge1);
        end else begin
            hit_pair.edge0 = chhist_pkg::sat_inc(mem_rd_data.edge0);
        end
    end

    assign hit_write = (state_reg == ST_BUSY) && (item_reg.func == chhist_pkg::FUNC_HIT)
                       && event_open_reg && item_reg.addr_ok;
    assign out_load  = (state_reg == ST_BUSY) && (item_reg.func == chhist_pkg::FUNC_QUERY)
                       && out_free;

    assign mem_wr_en   = (state_reg == ST_CLEAR) || hit_write;
    assign mem_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx_reg;
    assign mem_wr_data = (state_reg == ST_CLEAR) ? '0 : hit_pair;

    chhist_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (map_idx),
        .rd_data (mem_rd_data)
    );

    chhist_classify u_classify (
        .aclk        (aclk),
        .threshold   (threshold_reg),
        .event_total (event_total_reg),
        .addr_ok     (item_reg.addr_ok),
        .edge0       (mem_rd_data.edge0),
        .chan_class  (class_now)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(CHANNELS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY: begin
                // a query holds here until the result register is free
                if (item_reg.func != chhist_pkg::FUNC_QUERY || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= chhist_pkg::THRESHOLD_RST;
            req_trig_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                chhist_pkg::REG_THRESHOLD:   threshold_reg <= cfg_wdata;
                chhist_pkg::REG_REQ_TRIGGER: req_trig_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // event header handled at acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_total_reg <= '0;
            event_open_reg  <= 1'b0;
        end else if (accept && in_func == chhist_pkg::FUNC_HEADER) begin
            event_open_reg <= in_trig || !req_trig_reg;
            if (in_trig || !req_trig_reg) begin
                event_total_reg <= chhist_pkg::sat_inc(event_total_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg <= '0;
        end else if (accept) begin
            item_reg.func     <= in_func;
            item_reg.edge_sel <= s_tdata[16];
            item_reg.addr_ok  <= map_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg <= map_idx;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_e0_reg    <= item_reg.addr_ok ? mem_rd_data.edge0 : '0;
            out_e1_reg    <= item_reg.addr_ok ? mem_rd_data.edge1 : '0;
            out_total_reg <= event_total_reg;
            out_class_reg <= class_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_class_reg, out_total_reg, out_e1_reg, out_e0_reg};

`ifndef SYNTHESIS
    // a write-back never coincides with a new read of the memory
    assert property (@(posedge aclk) disable iff (!aresetn)
        hit_write |-> !accept)
        else $error("counter write-back overlaps a memory read");

    // a result appears only after a query
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (item_reg.func == chhist_pkg::FUNC_QUERY) && $past(accept, 1)
                     || $past(state_reg, 1) == ST_BUSY)
        else $error("result loaded without a query");

    // the event count never goes down
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn, 1) |-> event_total_reg >= $past(event_total_reg, 1))
        else $error("event count decreased");

    // no word is taken while the memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("word accepted during clearing");
`endif

endmodule

// ===== src/chhist_chan_map.sv =====
// ----------------------------------------------------------------------------
// chhist_chan_map
// Maps (arm, side, plane, cell) to a flat counter address and range-checks it.
// ----------------------------------------------------------------------------
module chhist_chan_map #(
    parameter int ARMS   = chhist_pkg::ARMS_DEF,
    parameter int SIDES  = chhist_pkg::SIDES_DEF,
    parameter int PLANES = chhist_pkg::PLANES_DEF,
    parameter int CELLS  = chhist_pkg::CELLS_DEF,
    parameter int AW     = 14
) (
    input  logic          arm,
    input  logic          side,
    input  logic [5:0]    plane,
    input  logic [6:0]    cell_no,
    output logic [AW-1:0] idx,
    output logic          ok
);

    logic arm_ok;
    logic side_ok;
    logic plane_ok;
    logic cell_ok;

    assign arm_ok   = {1'b0, arm} < 2'(ARMS);
    assign side_ok  = {1'b0, side} < 2'(SIDES);
    assign plane_ok = {1'b0, plane} < 7'(PLANES);
    assign cell_ok  = ({1'b0, cell_no} < 8'(CELLS)) && (cell_no <= chhist_pkg::CELL_LIMIT);
    assign ok       = arm_ok && side_ok && plane_ok && cell_ok;

    // products by constants only; address is meaningful only when ok
    assign idx = ((AW'(arm) * AW'(SIDES) + AW'(side)) * AW'(PLANES) + AW'(plane))
                 * AW'(CELLS) + AW'(cell_no);

endmodule

// ===== src/chhist_mem.sv =====
// ----------------------------------------------------------------------------
// chhist_mem
// Counter memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chhist_mem #(
    parameter int DEPTH = 12800,
    parameter int AW    = 14
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  chhist_pkg::cnt_pair_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output chhist_pkg::cnt_pair_t rd_data
);

    chhist_pkg::cnt_pair_t mem_arr [DEPTH];
    chhist_pkg::cnt_pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_arr[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_arr[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/chhist_classify.sv =====
// ----------------------------------------------------------------------------
// chhist_classify
// Noisy / dead / good / unknown decision: edge0 * 256 > threshold * event total.
// ----------------------------------------------------------------------------
module chhist_classify (
    input  logic                             aclk,
    input  logic [chhist_pkg::CFG_W-1:0]     threshold,
    input  logic [chhist_pkg::CNT_W-1:0]     event_total,
    input  logic                             addr_ok,
    input  logic [chhist_pkg::CNT_W-1:0]     edge0,
    output logic [1:0]                       chan_class
);

    localparam int PW = chhist_pkg::CFG_W + chhist_pkg::CNT_W;

    // limit registered every cycle from threshold and event total; a query reads it in the busy state
    logic [PW-1:0] limit_reg;
    logic [PW-1:0] scaled;

    always_ff @(posedge aclk) begin
        limit_reg <= PW'(threshold) * PW'(event_total);
    end

    assign scaled = PW'({edge0, 8'h00});

    always_comb begin
        priority if (!addr_ok || event_total == '0) begin
            chan_class = chhist_pkg::CLASS_UNKNOWN;
        end else if (scaled > limit_reg) begin
            chan_class = chhist_pkg::CLASS_NOISY;
        end else if (edge0 == '0) begin
            chan_class = chhist_pkg::CLASS_DEAD;
        end else begin
            chan_class = chhist_pkg::CLASS_GOOD;
        end
    end

endmodule

// ===== test/tb_channel_hit_histogram_noise_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_hit_histogram_noise_classifier
// Streams event headers, hits and channel queries into the histogram and
// compares every query reply with an in-bench histogram that keeps its own
// counters, event count and register copies. Directed corner cases come first,
// then random event sequences under several threshold and trigger settings,
// with random gaps on both sides outside the steady phase, and long result-side stalls.
// ----------------------------------------------------------------------------
module tb_channel_hit_histogram_noise_classifier;

    localparam int CNT_W        = chhist_pkg::CNT_W;
    localparam int CFG_W        = chhist_pkg::CFG_W;
    localparam int CHANNELS     = chhist_pkg::ARMS_DEF * chhist_pkg::SIDES_DEF
                                  * chhist_pkg::PLANES_DEF * chhist_pkg::CELLS_DEF;
    localparam int HOT_SPOTS    = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 20;
    localparam int WATCHDOG     = 40000;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic       trig;
        logic       arm;
        logic       side;
        logic [5:0] plane;
        logic [6:0] cell_no;
        logic       edge_sel;
    } word_t;

    typedef struct {
        logic [CNT_W-1:0] e0;
        logic [CNT_W-1:0] e1;
        logic [CNT_W-1:0] events;
        logic [1:0]       cls;
    } reply_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [chhist_pkg::S_DATA_W-1:0]     s_tdata;
    logic [1:0]                          s_tuser;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [chhist_pkg::M_DATA_W-1:0]     m_tdata;
    logic                                cfg_wr_en;
    logic [chhist_pkg::CFG_AW-1:0]       cfg_addr;
    logic [CFG_W-1:0]                    cfg_wdata;

    // histogram copy kept by the bench
    logic [CNT_W-1:0] hist_edge0 [CHANNELS];
    logic [CNT_W-1:0] hist_edge1 [CHANNELS];
    logic [CNT_W-1:0] event_total;
    logic             event_open;
    logic [CFG_W-1:0] thr_q;
    logic             req_trig_q;

    word_t  pending_words [$];
    reply_t query_replies [$];
    word_t  hot_spots [HOT_SPOTS];
    word_t  drv_word;

    bit          steady;
    bit          in_taken;
    int unsigned words_pushed;
    int unsigned words_taken;
    int unsigned results_seen;
    int unsigned next_hold;
    int unsigned hold_left;
    int unsigned stall_cycles;
    int unsigned errors;

    channel_hit_histogram_noise_classifier u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == chhist_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic histogram_update(input logic [1:0] func,
                                    input logic [chhist_pkg::S_DATA_W-1:0] d);
        logic             arm;
        logic             side;
        logic [5:0]       plane;
        logic [6:0]       cell_no;
        logic             addr_ok;
        int unsigned      idx;
        reply_t           r;
        logic [47:0]      scaled_hits;
        logic [47:0]      limit;
        arm     = d[1];
        side    = d[2];
        plane   = d[8:3];
        cell_no = d[15:9];
        addr_ok = (int'(arm) < chhist_pkg::ARMS_DEF) && (int'(side) < chhist_pkg::SIDES_DEF)
                  && (int'(plane) < chhist_pkg::PLANES_DEF)
                  && (int'(cell_no) < chhist_pkg::CELLS_DEF)
                  && (cell_no <= chhist_pkg::CELL_LIMIT);
        idx = 0;
        if (addr_ok)
            idx = ((int'(arm) * chhist_pkg::SIDES_DEF + int'(side)) * chhist_pkg::PLANES_DEF
                   + int'(plane)) * chhist_pkg::CELLS_DEF + int'(cell_no);
        case (func)
            chhist_pkg::FUNC_HEADER: begin
                event_open = d[0] || !req_trig_q;
                if (event_open)
                    event_total = bump(event_total);
            end
            chhist_pkg::FUNC_HIT: begin
                if (event_open && addr_ok) begin
                    if (!d[16])
                        hist_edge0[idx] = bump(hist_edge0[idx]);
                    else
                        hist_edge1[idx] = bump(hist_edge1[idx]);
                end
            end
            chhist_pkg::FUNC_QUERY: begin
                r.e0     = '0;
                r.e1     = '0;
                r.events = event_total;
                r.cls    = chhist_pkg::CLASS_UNKNOWN;
                if (addr_ok) begin
                    r.e0 = hist_edge0[idx];
                    r.e1 = hist_edge1[idx];
                    if (event_total != 0) begin
                        // hits per event against an 8.8 threshold, kept exact
                        scaled_hits = {16'd0, r.e0, 8'd0};
                        limit       = 48'(thr_q) * 48'(event_total);
                        if (scaled_hits > limit)
                            r.cls = chhist_pkg::CLASS_NOISY;
                        else if (r.e0 == 0)
                            r.cls = chhist_pkg::CLASS_DEAD;
                        else
                            r.cls = chhist_pkg::CLASS_GOOD;
                    end
                end
                query_replies.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: register copies, input words, result words
    always @(posedge aclk) begin
        reply_t r;
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_addr == chhist_pkg::REG_THRESHOLD)
                    thr_q = cfg_wdata;
                else if (cfg_addr == chhist_pkg::REG_REQ_TRIGGER)
                    req_trig_q = cfg_wdata[0];
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken) begin
                histogram_update(s_tuser, s_tdata);
                words_taken++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (query_replies.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    r = query_replies.pop_front();
                    check_field("edge0_count", r.e0, m_tdata[23:0]);
                    check_field("edge1_count", r.e1, m_tdata[47:24]);
                    check_field("accepted_events", r.events, m_tdata[71:48]);
                    check_field("channel_class", CNT_W'(r.cls), CNT_W'(m_tdata[73:72]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG) begin
            $display("status: fail");
            $finish;
        end
    end

    // input side driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_words.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
                drv_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, drv_word.edge_sel, drv_word.cell_no, drv_word.plane,
                             drv_word.side, drv_word.arm, drv_word.trig};
                s_tuser  <= drv_word.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: random gaps plus long hold-offs so the input backs up
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (results_seen >= next_hold) begin
            hold_left = HOLD_CYCLES;
            next_hold += 350;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 15);
        end
    end

    function automatic word_t mk_word(input logic [1:0] func, input bit trig, input bit arm,
                                      input bit side, input int unsigned plane,
                                      input int unsigned cell_no, input bit edge_sel);
        word_t w;
        w.func     = func;
        w.trig     = trig;
        w.arm      = arm;
        w.side     = side;
        w.plane    = 6'(plane);
        w.cell_no  = 7'(cell_no);
        w.edge_sel = edge_sel;
        return w;
    endfunction

    function automatic word_t random_word(input logic [1:0] func);
        word_t       w;
        int unsigned pick;
        pick       = $urandom_range(0, 99);
        w          = hot_spots[$urandom_range(0, HOT_SPOTS - 1)];
        w.func     = func;
        w.trig     = 1'($urandom_range(0, 1));
        w.edge_sel = 1'($urandom_range(0, 1));
        if (pick >= 90) begin
            // anything the fields allow, mostly out of range
            w.arm     = 1'($urandom_range(0, 1));
            w.side    = 1'($urandom_range(0, 1));
            w.plane   = 6'($urandom_range(0, 63));
            w.cell_no = 7'($urandom_range(0, 127));
        end else if (pick >= 70) begin
            w.arm     = 1'($urandom_range(0, chhist_pkg::ARMS_DEF - 1));
            w.side    = 1'($urandom_range(0, chhist_pkg::SIDES_DEF - 1));
            w.plane   = 6'($urandom_range(0, chhist_pkg::PLANES_DEF - 1));
            w.cell_no = 7'($urandom_range(0, chhist_pkg::CELLS_DEF - 1));
        end
        return w;
    endfunction

    task automatic push_word(input word_t w);
        pending_words.push_back(w);
        words_pushed++;
    endtask

    task automatic push_random(input int unsigned count);
        int unsigned n;
        int unsigned k;
        word_t       w;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 80) begin
                // header, a burst of hits, then a few queries
                w = random_word(chhist_pkg::FUNC_HEADER);
                w.trig = ($urandom_range(0, 9) != 0);
                push_word(w);
                n++;
                for (k = $urandom_range(1, 8); k != 0; k--) begin
                    push_word(random_word(chhist_pkg::FUNC_HIT));
                    n++;
                end
                for (k = $urandom_range(0, 2); k != 0; k--) begin
                    push_word(random_word(chhist_pkg::FUNC_QUERY));
                    n++;
                end
            end else begin
                w = random_word(2'($urandom_range(0, 3)));
                push_word(w);
                if (w.func != FUNC_SPARE)
                    n++;
            end
        end
    endtask

    task automatic write_reg(input logic [chhist_pkg::CFG_AW-1:0] addr,
                             input logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (words_taken != words_pushed || query_replies.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        steady     = 1'b0;
        in_taken   = 1'b0;
        next_hold  = 25;
        hold_left  = 0;
        stall_cycles = 0;
        errors     = 0;
        event_total = '0;
        event_open  = 1'b0;
        thr_q       = chhist_pkg::THRESHOLD_RST;
        req_trig_q  = 1'b1;
        foreach (hist_edge0[i]) begin
            hist_edge0[i] = '0;
            hist_edge1[i] = '0;
        end
        foreach (hot_spots[i])
            hot_spots[i] = mk_word(chhist_pkg::FUNC_HIT, 1'b0, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)),
                                   $urandom_range(0, chhist_pkg::PLANES_DEF - 1),
                                   $urandom_range(0, chhist_pkg::CELLS_DEF - 1), 1'b0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners under the reset register values
        push_word(mk_word(chhist_pkg::FUNC_QUERY,  0, 0, 0, 0, 0, 0));    // no events yet
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 0, 0, 0, 0, 0));    // hit before header
        push_word(mk_word(FUNC_SPARE,              1, 1, 1, 63, 127, 1)); // unused kind
        push_word(mk_word(chhist_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 0));    // rejected event
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 1, 1, 39, 79, 1));
        push_word(mk_word(chhist_pkg::FUNC_HEADER, 1, 0, 0, 0, 0, 0));
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 0, 0, 0, 0, 0));
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 0, 0, 0, 0, 0));
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 0, 0, 0, 0, 1));
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 1, 1, 39, 79, 0));
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 1, 1, 39, 79, 1));
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 0, 0, 40, 0, 0));   // plane past the last
        push_word(mk_word(chhist_pkg::FUNC_HIT,    1, 1, 1, 63, 127, 1));
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 0, 0, 0, 80, 0));   // cell past the limit
        push_word(mk_word(chhist_pkg::FUNC_QUERY,  0, 0, 0, 0, 0, 0));
        push_word(mk_word(chhist_pkg::FUNC_QUERY,  0, 1, 1, 39, 79, 0));
        push_word(mk_word(chhist_pkg::FUNC_QUERY,  0, 0, 1, 5, 5, 0));
        push_word(mk_word(chhist_pkg::FUNC_QUERY,  1, 1, 1, 63, 127, 1)); // bad address
        push_word(mk_word(chhist_pkg::FUNC_QUERY,  0, 0, 0, 0, 80, 0));
        push_word(mk_word(chhist_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 0));    // header over open event
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 0, 1, 5, 5, 0));
        push_word(mk_word(chhist_pkg::FUNC_HEADER, 1, 0, 0, 0, 0, 0));
        push_word(mk_word(chhist_pkg::FUNC_HIT,    0, 0, 1, 5, 5, 0));
        push_word(mk_word(chhist_pkg::FUNC_QUERY,  0, 0, 1, 5, 5, 0));    // exactly at threshold
        push_word(mk_word(chhist_pkg::FUNC_QUERY,  0, 0, 0, 0, 0, 0));
        wait_idle();

        write_reg(chhist_pkg::REG_THRESHOLD, '0);
        write_reg(chhist_pkg::REG_REQ_TRIGGER, '0);
        push_random(240);
        wait_idle();

        steady = 1'b1;
        write_reg(chhist_pkg::REG_THRESHOLD, 16'hFFFF);
        write_reg(chhist_pkg::REG_REQ_TRIGGER, 16'd1);
        push_random(240);
        wait_idle();
        steady = 1'b0;

        write_reg(chhist_pkg::REG_THRESHOLD, chhist_pkg::THRESHOLD_RST);
        push_random(240);
        wait_idle();

        write_reg(chhist_pkg::REG_THRESHOLD, CFG_W'($urandom_range(0, 65535)));
        write_reg(chhist_pkg::REG_REQ_TRIGGER, CFG_W'($urandom_range(0, 1)));
        push_random(240);
        wait_idle();

        write_reg(chhist_pkg::REG_THRESHOLD, 16'd256);
        write_reg(chhist_pkg::REG_REQ_TRIGGER, '0);
        push_random(240);
        wait_idle();

        if (errors == 0 && query_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
